@@ sv/pipc_pkg.sv @@
// ----------------------------------------------------------------------------
// pipc_pkg
// Shared widths, register indexes, reset values, codes and the command
// struct of the PI position controller.
// ----------------------------------------------------------------------------
package pipc_pkg;

    // Field widths
    localparam int TARGET_W = 8;
    localparam int COUNT_W  = 14;
    localparam int GAIN_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int DIR_W    = 2;
    localparam int CTL_W    = 16;
    localparam int ERR_W    = 11;
    localparam int DERR_W   = 12;
    localparam int SUM_W    = 16;
    localparam int ACC_W    = 30;
    localparam int MUL_A_W  = GAIN_W + 1;
    localparam int MUL_B_W  = 15;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int FRAC_W   = 8;

    // Bus widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_TS_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENCODER_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 3'd4;

    // Register reset values
    localparam logic [GAIN_W-1:0] KP_RESET    = 16'd128;
    localparam logic [GAIN_W-1:0] KI_RESET    = 16'd0;
    localparam logic [GAIN_W-1:0] SCALE_RESET = 16'd1857;
    localparam logic [BYTE_W-1:0] DZ_RESET    = 8'd5;
    localparam logic [BYTE_W-1:0] MAXS_RESET  = 8'd255;

    // Error saturation limits
    localparam logic signed [SUM_W-1:0] ERR_MIN = -16'sd1024;
    localparam logic signed [SUM_W-1:0] ERR_MAX = 16'sd1023;

    // Controller output saturation limits
    localparam logic signed [ACC_W-1:0] OUT_MIN = -30'sd32768;
    localparam logic signed [ACC_W-1:0] OUT_MAX = 30'sd32767;

    // Drive direction codes
    localparam logic [DIR_W-1:0] DIR_STOP  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;

    // Multiplier operand select
    localparam logic [1:0] MUL_SCALE = 2'd0;
    localparam logic [1:0] MUL_KP    = 2'd1;
    localparam logic [1:0] MUL_KI    = 2'd2;

    // Datapath command from the controller
    typedef struct packed {
        logic       load_in;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       err_en;
        logic       p_en;
        logic       acc_en;
        logic       out_load;
    } cmd_t;

endpackage

@@ sv/pipc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pipc_ctrl
// Sequencer of the PI position controller: steps one sample through scale,
// error, two gain products, accumulate and output load.
// ----------------------------------------------------------------------------
module pipc_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            out_free,
    output pipc_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_ERR   = 3'd2;
    localparam logic [2:0] S_MULP  = 3'd3;
    localparam logic [2:0] S_MULI  = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_sel  = pipc_pkg::MUL_SCALE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pipc_pkg::MUL_SCALE;
                state_next  = S_ERR;
            end
            S_ERR:
            begin
                cmd.err_en = 1'b1;
                state_next = S_MULP;
            end
            S_MULP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pipc_pkg::MUL_KP;
                state_next  = S_MULI;
            end
            S_MULI:
            begin
                cmd.p_en    = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pipc_pkg::MUL_KI;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register can take the word
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/pipc_datapath.sv @@
// ----------------------------------------------------------------------------
// pipc_datapath
// Configuration registers, shared gain multiplier, error and accumulator
// logic, controller state and the output register.
// ----------------------------------------------------------------------------
module pipc_datapath
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  pipc_pkg::cmd_t                           cmd,
    input  logic                                     cfg_we,
    input  logic [pipc_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [pipc_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic signed [pipc_pkg::TARGET_W-1:0]     target_position,
    input  logic [pipc_pkg::COUNT_W-1:0]             encoder_count,
    input  logic                                     out_ready,
    output logic                                     out_valid,
    output logic                                     out_free,
    output logic [pipc_pkg::DIR_W-1:0]               drive_direction,
    output logic [pipc_pkg::BYTE_W-1:0]              drive_speed,
    output logic signed [pipc_pkg::CTL_W-1:0]        control_value
);

    // Configuration
    logic [pipc_pkg::GAIN_W-1:0] kp_reg;
    logic [pipc_pkg::GAIN_W-1:0] ki_reg;
    logic [pipc_pkg::GAIN_W-1:0] scale_reg;
    logic [pipc_pkg::BYTE_W-1:0] dz_reg;
    logic [pipc_pkg::BYTE_W-1:0] maxs_reg;

    // Sample and working registers
    logic signed [pipc_pkg::TARGET_W-1:0] target_reg;
    logic [pipc_pkg::COUNT_W-1:0]         count_reg;
    logic signed [pipc_pkg::PROD_W-1:0]   prod_reg;
    logic signed [pipc_pkg::PROD_W-1:0]   p_reg;
    logic signed [pipc_pkg::ERR_W-1:0]    err_reg;
    logic signed [pipc_pkg::DERR_W-1:0]   derr_reg;

    // Controller state
    logic signed [pipc_pkg::ERR_W-1:0]    prev_err_reg;
    logic signed [pipc_pkg::CTL_W-1:0]    prev_out_reg;

    // Output register
    logic                                 out_valid_reg;
    logic [pipc_pkg::DIR_W-1:0]           dir_reg;
    logic [pipc_pkg::BYTE_W-1:0]          speed_reg;
    logic signed [pipc_pkg::CTL_W-1:0]    ctl_reg;

    // Combinational values
    logic signed [pipc_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [pipc_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [pipc_pkg::PROD_W-1:0]   mul_p;
    logic signed [pipc_pkg::SUM_W-1:0]    err_sum;
    logic signed [pipc_pkg::ERR_W-1:0]    err_sat;
    logic signed [pipc_pkg::DERR_W-1:0]   derr_next;
    logic signed [pipc_pkg::ACC_W-1:0]    acc;
    logic signed [pipc_pkg::ACC_W-1:0]    acc_rnd;
    logic signed [pipc_pkg::ACC_W-1:0]    quot;
    logic signed [pipc_pkg::CTL_W-1:0]    ctl_next;
    logic signed [pipc_pkg::CTL_W:0]      ctl_ext;
    logic signed [pipc_pkg::CTL_W:0]      dz_ext;
    logic [pipc_pkg::DIR_W-1:0]           dir_next;
    logic [pipc_pkg::CTL_W:0]             mag;
    logic [pipc_pkg::BYTE_W-1:0]          speed_next;

    // Shared signed multiplier: unsigned 16-bit gain against a signed operand
    always_comb
    begin
        unique case (cmd.mul_sel)
            pipc_pkg::MUL_SCALE:
            begin
                mul_a = $signed({1'b0, scale_reg});
                mul_b = $signed({1'b0, count_reg});
            end
            pipc_pkg::MUL_KP:
            begin
                mul_a = $signed({1'b0, kp_reg});
                mul_b = pipc_pkg::MUL_B_W'(derr_reg);
            end
            pipc_pkg::MUL_KI:
            begin
                mul_a = $signed({1'b0, ki_reg});
                mul_b = pipc_pkg::MUL_B_W'(err_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Error: target plus the truncated scaled count, saturated to 11 bits
    always_comb
    begin
        err_sum = pipc_pkg::SUM_W'(target_reg)
                + $signed({2'b00, prod_reg[pipc_pkg::COUNT_W+15:16]});
        if (err_sum < pipc_pkg::ERR_MIN)
        begin
            err_sat = pipc_pkg::ERR_W'(pipc_pkg::ERR_MIN);
        end
        else if (err_sum > pipc_pkg::ERR_MAX)
        begin
            err_sat = pipc_pkg::ERR_W'(pipc_pkg::ERR_MAX);
        end
        else
        begin
            err_sat = pipc_pkg::ERR_W'(err_sum);
        end
        derr_next = pipc_pkg::DERR_W'(err_sat) - pipc_pkg::DERR_W'(prev_err_reg);
    end

    // Accumulate in Q22.8, divide by 256 toward zero, saturate to 16 bits
    always_comb
    begin
        acc = pipc_pkg::ACC_W'(p_reg) + pipc_pkg::ACC_W'(prod_reg)
            + (pipc_pkg::ACC_W'(prev_out_reg) <<< pipc_pkg::FRAC_W);
        acc_rnd = acc[pipc_pkg::ACC_W-1] ? (acc + pipc_pkg::ACC_W'(255)) : acc;
        quot    = acc_rnd >>> pipc_pkg::FRAC_W;
        if (quot < pipc_pkg::OUT_MIN)
        begin
            ctl_next = pipc_pkg::CTL_W'(pipc_pkg::OUT_MIN);
        end
        else if (quot > pipc_pkg::OUT_MAX)
        begin
            ctl_next = pipc_pkg::CTL_W'(pipc_pkg::OUT_MAX);
        end
        else
        begin
            ctl_next = pipc_pkg::CTL_W'(quot);
        end
    end

    // Deadzone and speed clamp on the stored output
    always_comb
    begin
        ctl_ext = (pipc_pkg::CTL_W+1)'(prev_out_reg);
        dz_ext  = $signed({1'b0, pipc_pkg::BYTE_W'(0), dz_reg});
        priority if (ctl_ext < -dz_ext)
        begin
            dir_next = pipc_pkg::DIR_LEFT;
            mag      = unsigned'(-ctl_ext);
        end
        else if (ctl_ext > dz_ext)
        begin
            dir_next = pipc_pkg::DIR_RIGHT;
            mag      = unsigned'(ctl_ext);
        end
        else
        begin
            dir_next = pipc_pkg::DIR_STOP;
            mag      = '0;
        end
        if (mag > {1'b0, pipc_pkg::BYTE_W'(0), maxs_reg})
        begin
            speed_next = maxs_reg;
        end
        else
        begin
            speed_next = mag[pipc_pkg::BYTE_W-1:0];
        end
    end

    // Configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg       <= pipc_pkg::KP_RESET;
            ki_reg       <= pipc_pkg::KI_RESET;
            scale_reg    <= pipc_pkg::SCALE_RESET;
            dz_reg       <= pipc_pkg::DZ_RESET;
            maxs_reg     <= pipc_pkg::MAXS_RESET;
            prev_err_reg <= '0;
            prev_out_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pipc_pkg::REG_KP_GAIN:       kp_reg    <= cfg_data;
                    pipc_pkg::REG_KI_TS_GAIN:    ki_reg    <= cfg_data;
                    pipc_pkg::REG_ENCODER_SCALE: scale_reg <= cfg_data;
                    pipc_pkg::REG_DEADZONE:      dz_reg    <= cfg_data[pipc_pkg::BYTE_W-1:0];
                    pipc_pkg::REG_MAX_SPEED:     maxs_reg  <= cfg_data[pipc_pkg::BYTE_W-1:0];
                    default:                     ;
                endcase
            end
            if (cmd.acc_en)
            begin
                prev_err_reg <= err_reg;
                prev_out_reg <= ctl_next;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            target_reg <= target_position;
            count_reg  <= encoder_count;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.p_en)
        begin
            p_reg <= prod_reg;
        end
        if (cmd.err_en)
        begin
            err_reg  <= err_sat;
            derr_reg <= derr_next;
        end
        if (cmd.out_load)
        begin
            dir_reg   <= dir_next;
            speed_reg <= speed_next;
            ctl_reg   <= prev_out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_free        = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign drive_direction = dir_reg;
    assign drive_speed     = speed_reg;
    assign control_value   = ctl_reg;

endmodule

@@ sv/pi_position_controller_core.sv @@
// ----------------------------------------------------------------------------
// pi_position_controller_core
// Velocity-form PI position controller with deadzone drive decision.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one word per sample tick, carrying the signed target
//   position and the raw encoder count. Master channel m_*: one word per
//   sample with drive direction, clamped drive speed and the saturated
//   controller output. Config port cfg_*: write gains, encoder scale,
//   deadzone and max speed by index; write only while no sample is in flight.
// Sequence: scale multiply, error, kp product, ki product, accumulate and
//   output load run in turn through one shared 17x15 multiplier. A sample
//   holds the block until its output load step, so a new word is accepted
//   only after the previous one has been loaded into the output register.
// Stall: the output register holds its word until m_tready; a new sample is
//   accepted meanwhile and is processed up to the output load step, where
//   the sequencer waits for the register to free up.
// Reset: rst_n clears the sequencer, the output valid flag and the stored
//   previous error and output, and returns all config registers to defaults.
// ----------------------------------------------------------------------------
module pi_position_controller_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // tdata: [7:0] target_position, [21:8] encoder_count, [23:22] zero
    input  logic [pipc_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata: [1:0] drive_direction, [9:2] drive_speed, [25:10] control_value,
    //        [31:26] zero
    output logic [pipc_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_we,
    input  logic [pipc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pipc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pipc_pkg::cmd_t                         cmd;
    logic                                   out_free;
    logic [pipc_pkg::DIR_W-1:0]             drive_direction;
    logic [pipc_pkg::BYTE_W-1:0]            drive_speed;
    logic signed [pipc_pkg::CTL_W-1:0]      control_value;

    pipc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .cmd      (cmd)
    );

    pipc_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .target_position (s_tdata[pipc_pkg::TARGET_W-1:0]),
        .encoder_count   (s_tdata[pipc_pkg::TARGET_W+pipc_pkg::COUNT_W-1:pipc_pkg::TARGET_W]),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_free        (out_free),
        .drive_direction (drive_direction),
        .drive_speed     (drive_speed),
        .control_value   (control_value)
    );

    // pack the result word, lowest field first
    assign m_tdata = {6'd0, control_value, drive_speed, drive_direction};

    // A sample is taken only from idle, so no second word is taken right after
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a sample is in flight");

    // Stopped drive never reports a speed
    a_stop_no_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (drive_direction == pipc_pkg::DIR_STOP)) |-> (drive_speed == 8'd0))
        else $error("speed given while stopped");

    // Left drive comes only with a negative controller output
    a_dir_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (drive_direction == pipc_pkg::DIR_LEFT)) |-> control_value[15])
        else $error("left drive with non-negative output");

    // A new result word appears only after the block left idle
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result word without a sample in flight");

endmodule
